[src/xcfr_pkg.sv]
`default_nettype none

package xcfr_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE    = 3'd0,
    REG_END_BYTE      = 3'd1,
    REG_LINK_TYPE     = 3'd2,
    REG_SPEED_TYPE    = 3'd3,
    REG_SPEED_FLOOR   = 3'd4,
    REG_SPEED_CEILING = 3'd5,
    REG_TIMEOUT_TICKS = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0]  RST_START_BYTE    = 8'd165;
  localparam logic [7:0]  RST_END_BYTE      = 8'd90;
  localparam logic [7:0]  RST_LINK_TYPE     = 8'd1;
  localparam logic [7:0]  RST_SPEED_TYPE    = 8'd2;
  localparam logic [7:0]  RST_SPEED_FLOOR   = 8'd0;
  localparam logic [7:0]  RST_SPEED_CEILING = 8'd255;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd2000;

  // Idle counter saturation value
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // Result queue geometry
  localparam int QDEPTH = 3;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  link_type;
    logic [7:0]  speed_type;
    logic [7:0]  speed_floor;
    logic [7:0]  speed_ceiling;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       speed_update;
    logic [7:0] speed_value;
    logic       link_up;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } q_wr_t;

  // Frame parser phases
  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_CHECK = 5'b01000,
    PH_END   = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

[src/xor_checked_frame_receiver.sv]
// A result passes through the input register and then the result queue to the out_ ports.
// Throughput: one item per cycle, bytes and ticks alike, unless in_stall holds input off;
//   the parser and idle counter update combinationally from the input register, and a
//   three-entry result queue keeps input flowing while a result waits.
// Reset: synchronous active-low rst_n clears the parser, idle counter, link flag and
//   queue, and loads the configuration registers with their defaults.
`default_nettype none

module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_speed_update,
  output logic [7:0]                 out_speed_value,
  output logic                       out_link_up,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg;
  q_wr_t             q_wr;
  logic [QPTR_W-1:0] q_level;
  result_t           out_data;

  xcfr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  xcfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg),
    .q_level    (q_level),
    .q_wr       (q_wr)
  );

  xcfr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_wr      (q_wr),
    .q_level   (q_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_speed_update = out_data.speed_update;
  assign out_speed_value  = out_data.speed_value;
  assign out_link_up      = out_data.link_up;

endmodule

`default_nettype wire

[src/xcfr_regs.sv]
`default_nettype none

module xcfr_regs
  import xcfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always ready for a write beat
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index, drop writes beyond the list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_BYTE:    cfg_nxt.start_byte    = cfg_wdata[7:0];
        REG_END_BYTE:      cfg_nxt.end_byte      = cfg_wdata[7:0];
        REG_LINK_TYPE:     cfg_nxt.link_type     = cfg_wdata[7:0];
        REG_SPEED_TYPE:    cfg_nxt.speed_type    = cfg_wdata[7:0];
        REG_SPEED_FLOOR:   cfg_nxt.speed_floor   = cfg_wdata[7:0];
        REG_SPEED_CEILING: cfg_nxt.speed_ceiling = cfg_wdata[7:0];
        REG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= RST_START_BYTE;
      cfg_r.end_byte      <= RST_END_BYTE;
      cfg_r.link_type     <= RST_LINK_TYPE;
      cfg_r.speed_type    <= RST_SPEED_TYPE;
      cfg_r.speed_floor   <= RST_SPEED_FLOOR;
      cfg_r.speed_ceiling <= RST_SPEED_CEILING;
      cfg_r.timeout_ticks <= RST_TIMEOUT_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[src/xcfr_core.sv]
`default_nettype none

module xcfr_core
  import xcfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_rx_byte,
  input  wire cfg_t              cfg,
  input  wire logic [QPTR_W-1:0] q_level,
  output q_wr_t                  q_wr
);

  // Input register
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_byte_r;

  // Receiver state
  phase_t      phase_r,     phase_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_data_r, held_data_nxt;
  logic [15:0] idle_r,      idle_nxt;
  logic        link_r,      link_nxt;

  logic        upd;
  logic [7:0]  spd;
  logic [7:0]  floored;
  logic [7:0]  clamped;
  logic [QPTR_W-1:0] occupancy;

  // Hold off a beat when the queue entries plus the input register item reach the queue depth
  assign occupancy = q_level + {{(QPTR_W-1){1'b0}}, s1_valid_r};
  assign in_stall  = (occupancy == QPTR_W'(QDEPTH));

  // Clamp the speed: floor first, then ceiling
  assign floored = (held_data_r < cfg.speed_floor) ? cfg.speed_floor : held_data_r;
  assign clamped = (floored > cfg.speed_ceiling) ? cfg.speed_ceiling : floored;

  // Advance the parser and the link monitor for the item in the input register
  always_comb begin
    phase_nxt     = phase_r;
    held_type_nxt = held_type_r;
    held_data_nxt = held_data_r;
    idle_nxt      = idle_r;
    link_nxt      = link_r;
    upd           = 1'b0;
    spd           = '0;
    if (s1_valid_r) begin
      if (s1_mode_r) begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + 16'd1;
        end
      end else begin
        case (phase_r)
          PH_START: begin
            if (s1_byte_r == cfg.start_byte) begin
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            held_type_nxt = s1_byte_r;
            phase_nxt     = PH_DATA;
          end
          PH_DATA: begin
            held_data_nxt = s1_byte_r;
            phase_nxt     = PH_CHECK;
          end
          PH_CHECK: begin
            phase_nxt = ((held_type_r ^ held_data_r) == s1_byte_r) ? PH_END : PH_START;
          end
          PH_END: begin
            if (s1_byte_r == cfg.end_byte) begin
              if (held_type_r == cfg.link_type && held_data_r == 8'd0) begin
                link_nxt = 1'b1;
                idle_nxt = '0;
              end else if (held_type_r == cfg.speed_type) begin
                upd = 1'b1;
                spd = clamped;
              end
            end
            phase_nxt = PH_START;
          end
          default: phase_nxt = PH_START;
        endcase
      end
      // Drop the link once the idle count reaches the timeout
      if (idle_nxt >= cfg.timeout_ticks) begin
        link_nxt = 1'b0;
      end
    end
  end

  // Push one result per item into the queue
  assign q_wr.push              = s1_valid_r;
  assign q_wr.data.speed_update = upd;
  assign q_wr.data.speed_value  = spd;
  assign q_wr.data.link_up      = link_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_START;
      held_type_r <= '0;
      held_data_r <= '0;
      idle_r      <= '0;
      link_r      <= 1'b0;
    end else begin
      s1_valid_r  <= in_valid && !in_stall;
      phase_r     <= phase_nxt;
      held_type_r <= held_type_nxt;
      held_data_r <= held_data_nxt;
      idle_r      <= idle_nxt;
      link_r      <= link_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

[src/xcfr_outq.sv]
`default_nettype none

module xcfr_outq
  import xcfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_wr_t             q_wr,
  output logic [QPTR_W-1:0]      q_level,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output result_t                out_data
);

  result_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0] cnt_r,    cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign q_level   = cnt_r;
  assign pop       = out_valid && !out_stall;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !q_wr.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed result
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      entry_r[wr_ptr_r] <= q_wr.data;
    end
  end

endmodule

`default_nettype wire

[src/xcfr_checker.sv]
`default_nettype none

module xcfr_checker
  import xcfr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_mode,
  input wire logic [7:0]            in_rx_byte,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_speed_update,
  input wire logic [7:0]            out_speed_value,
  input wire logic                  out_link_up,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not empty after reset");

  // Input is only held off while results are waiting
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A result on an empty output comes from an accepted beat that passed through the input register
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input beat");

  // Speed value is zero unless a speed update is reported
  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_speed_update |-> out_speed_value == 8'd0)
    else $error("speed value set without speed update");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_speed_update)
      && $stable(out_speed_value) && $stable(out_link_up))
    else $error("stalled result beat changed");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (.*);

`default_nettype wire
